/* rtl/sad_block_motion_search_unit_assert.svh */
// ----------------------------------------------------------------------------
// sad_block_motion_search_unit_assert
// Assertion macros for the motion search unit.
// ----------------------------------------------------------------------------
`ifndef SAD_BLOCK_MOTION_SEARCH_UNIT_ASSERT_SVH
`define SAD_BLOCK_MOTION_SEARCH_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SBMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SBMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/sbms_pkg.sv */
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants of the SAD motion search unit.
// ----------------------------------------------------------------------------
package sbms_pkg;
    localparam int MAX_BLOCK_SIDE_DEF = 32;
    localparam int MAX_SCOPE_DEF      = 7;
    localparam int WIN_STRIDE_DEF     = 48;

    localparam logic [1:0] CMD_LOAD_REF = 2'd0;
    localparam logic [1:0] CMD_LOAD_WIN = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCOPE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAND,     // set up candidate
        ST_PIX,      // stream pixels of candidate
        ST_DRAIN,    // wait for datapath pipeline
        ST_CMP,      // compare candidate SAD against best
        ST_NEXTC,    // step candidate
        ST_PHASE,    // coarse done, decide on fine
        ST_DIV,      // divide best SAD by area
        ST_OUT       // hold result
    } sbms_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       clear_sad;   // clear accumulator for a new candidate
        logic       pix_en;      // issue one pixel read pair
        logic       cmp;         // compare accumulator with best
        logic       clear_best;  // reset best for a new search phase
        logic       div_start;
        logic       div_step;
    } sbms_cmd_t;
endpackage

/* rtl/sad_block_motion_search_unit.sv */
// ----------------------------------------------------------------------------
// sad_block_motion_search_unit
// Full-search SAD block matcher with coarse step-2 and fine step-1 passes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: load a reference pixel, load a window pixel,
//   or start a search. Loads give no result; the block takes a load in
//   every cycle while idle.
//   A start walks every candidate offset; each candidate streams w*h pixel
//   pairs from the two stores (one read port each).
//   Fine search: 9 candidates; refine mode adds (scope+1)^2 coarse ones.
//   After the last candidate a bit-serial divider forms the mean SAD; a
//   refine search whose coarse pass lands on zero ends after its last
//   coarse candidate.
//   m_axis carries one result per start. While the receiver stalls, the
//   result holds and no new item is accepted.
//   Reset restores 16x16 blocks and scope 4; store contents stay undefined
//   until written, with no clearing pass.
// ----------------------------------------------------------------------------
module sad_block_motion_search_unit import sbms_pkg::*; #(
    parameter int MAX_BLOCK_SIDE = MAX_BLOCK_SIDE_DEF,
    parameter int MAX_SCOPE      = MAX_SCOPE_DEF,
    parameter int WIN_STRIDE     = WIN_STRIDE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], pixel_row[7:2], pixel_col[13:8], pixel_value[21:14], refine[22]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mv_x[4:0], mv_y[9:5], mean_sad[17:10], updated[18]
    output logic [23:0] m_tdata
);
    localparam int RA = $clog2(MAX_BLOCK_SIDE);

    logic [5:0] bw_reg, bh_reg;
    logic [2:0] scope_reg;
    logic [1:0] cmd_in;
    logic [5:0] row_in, col_in;
    logic       acc, start, busy, better, div_done, out_valid, updated;
    logic [RA:0] w, h;
    logic [3:0] scope;
    logic [RA-1:0] px, py;
    logic signed [7:0] win_r, win_c;
    logic signed [4:0] mv_x, mv_y;
    logic [7:0] quot;
    sbms_cmd_t cmd;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg <= 6'd16; bh_reg <= 6'd16; scope_reg <= 3'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:  bw_reg    <= cfg_wdata;
                REG_HEIGHT: bh_reg    <= cfg_wdata;
                REG_SCOPE:  scope_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Clamp sides and scope to what the stores hold.
    assign w = (bw_reg == 0) ? (RA+1)'(1) :
               (7'(bw_reg) > 7'(MAX_BLOCK_SIDE)) ? (RA+1)'(MAX_BLOCK_SIDE) : (RA+1)'(bw_reg);
    assign h = (bh_reg == 0) ? (RA+1)'(1) :
               (7'(bh_reg) > 7'(MAX_BLOCK_SIDE)) ? (RA+1)'(MAX_BLOCK_SIDE) : (RA+1)'(bh_reg);
    assign scope = (4'(scope_reg) > 4'(MAX_SCOPE)) ? 4'(MAX_SCOPE) : 4'(scope_reg);

    assign cmd_in = s_tdata[1:0];
    assign row_in = s_tdata[7:2];
    assign col_in = s_tdata[13:8];
    assign s_tready = !busy;
    assign acc = s_tvalid && s_tready;
    assign start = acc && cmd_in == CMD_START;

    sbms_controller #(.MAX_BLOCK_SIDE(MAX_BLOCK_SIDE)) u_ctrl (
        .aclk, .aresetn, .start, .refine(s_tdata[22]), .w, .h, .scope,
        .better, .div_done, .out_taken(m_tready), .cmd, .px, .py,
        .win_r, .win_c, .busy, .out_valid, .mv_x, .mv_y, .updated
    );

    sbms_datapath #(.MAX_BLOCK_SIDE(MAX_BLOCK_SIDE), .WIN_STRIDE(WIN_STRIDE)) u_dp (
        .aclk, .aresetn,
        .ref_we(acc && cmd_in == CMD_LOAD_REF && 7'(row_in) < 7'(MAX_BLOCK_SIDE)
                && 7'(col_in) < 7'(MAX_BLOCK_SIDE)),
        .win_we(acc && cmd_in == CMD_LOAD_WIN && 7'(row_in) < 7'(WIN_STRIDE)
                && 7'(col_in) < 7'(WIN_STRIDE)),
        .wr_row(row_in), .wr_col(col_in), .wr_val(s_tdata[21:14]),
        .cmd, .px, .py, .win_r, .win_c,
        .area((2*RA+2)'(w) * (2*RA+2)'(h)),
        .better, .div_done, .quot
    );

    assign m_tvalid = out_valid;
    assign m_tdata = {5'd0, updated, updated ? quot : 8'd0, mv_y, mv_x};

    `include "sad_block_motion_search_unit_assert.svh"
    // No input is taken while a search runs or a result waits.
    `SBMS_ASSERT_IMP(a_no_accept_busy, m_tvalid, !s_tready)
    // A held result stays put until transferred.
    `SBMS_ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A start leads into a busy search.
    `SBMS_ASSERT_NEXT(a_start_busy, start, !s_tready)
endmodule

/* rtl/sbms_datapath.sv */
// ----------------------------------------------------------------------------
// sbms_datapath
// Pixel stores, SAD accumulator, best tracking and serial divider.
// ----------------------------------------------------------------------------
module sbms_datapath import sbms_pkg::*; #(
    parameter int MAX_BLOCK_SIDE = MAX_BLOCK_SIDE_DEF,
    parameter int WIN_STRIDE     = WIN_STRIDE_DEF,
    localparam int RA  = $clog2(MAX_BLOCK_SIDE),
    localparam int WA  = $clog2(WIN_STRIDE),
    localparam int RIW = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE),
    localparam int WIW = $clog2(WIN_STRIDE * WIN_STRIDE),
    localparam int SW  = 2 * RA + 10,
    localparam int AW  = 2 * RA + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ref_we,
    input  logic             win_we,
    input  logic [5:0]       wr_row,
    input  logic [5:0]       wr_col,
    input  logic [7:0]       wr_val,
    input  sbms_cmd_t        cmd,
    input  logic [RA-1:0]    px,
    input  logic [RA-1:0]    py,
    input  logic signed [7:0] win_r,   // window row of pixel, may be outside
    input  logic signed [7:0] win_c,
    input  logic [AW-1:0]    area,
    output logic             better,   // accumulator below best at compare
    output logic             div_done,
    output logic [7:0]       quot
);
    logic [7:0] ref_mem [MAX_BLOCK_SIDE*MAX_BLOCK_SIDE];
    logic [7:0] win_mem [WIN_STRIDE*WIN_STRIDE];
    logic [7:0] ref_q_reg, win_q_reg;
    logic       pv_reg;
    logic [SW-1:0] sad_reg, best_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] num_reg;
    logic [7:0]    q_reg;
    logic [$clog2(SW+1)-1:0] dcnt_reg;
    logic          dbusy_reg;
    logic          inw;
    logic [7:0]    diff;
    logic [SW:0]   trial;
    logic [RIW-1:0] ref_wa, ref_ra;
    logic [WIW-1:0] win_wa, win_ra;

    assign ref_wa = RIW'(wr_row[RA-1:0]) * RIW'(MAX_BLOCK_SIDE) + RIW'(wr_col[RA-1:0]);
    assign win_wa = WIW'(wr_row[WA-1:0]) * WIW'(WIN_STRIDE) + WIW'(wr_col[WA-1:0]);
    assign ref_ra = RIW'(py) * RIW'(MAX_BLOCK_SIDE) + RIW'(px);
    assign win_ra = WIW'(win_r[WA-1:0]) * WIW'(WIN_STRIDE) + WIW'(win_c[WA-1:0]);

    always_ff @(posedge aclk) begin
        if (ref_we)
            ref_mem[ref_wa] <= wr_val;
        if (win_we)
            win_mem[win_wa] <= wr_val;
    end

    assign inw = (win_r >= 0) && (win_r < WIN_STRIDE) && (win_c >= 0) && (win_c < WIN_STRIDE);

    always_ff @(posedge aclk) begin
        ref_q_reg <= ref_mem[ref_ra];
        win_q_reg <= inw ? win_mem[win_ra] : 8'd0;
    end

    assign diff = (ref_q_reg > win_q_reg) ? ref_q_reg - win_q_reg : win_q_reg - ref_q_reg;
    assign better = sad_reg < best_reg;

    // Accumulate after the registered read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.pix_en;
        end
        if (cmd.clear_sad)
            sad_reg <= '0;
        else if (pv_reg)
            sad_reg <= sad_reg + SW'(diff);
        if (cmd.clear_best)
            best_reg <= '1;
        else if (cmd.cmp && better)
            best_reg <= sad_reg;
    end

    // Restoring divider, one quotient bit a cycle; quotient kept to 8 bits.
    assign trial = {rem_reg, num_reg[SW-1]} - {{(SW-AW+1){1'b0}}, area};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= ($clog2(SW+1))'(SW);
        end else if (dbusy_reg && dcnt_reg == 1) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (dbusy_reg) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            num_reg <= best_reg;
            q_reg   <= '0;
        end else if (dbusy_reg) begin
            if (!trial[SW] || rem_reg[SW-1]) begin
                rem_reg <= trial[SW-1:0];
                q_reg   <= {q_reg[6:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[SW-2:0], num_reg[SW-1]};
                q_reg   <= {q_reg[6:0], 1'b0};
            end
            num_reg <= {num_reg[SW-2:0], 1'b0};
        end
    end
    assign div_done = dbusy_reg && dcnt_reg == 1;
    assign quot = q_reg;
endmodule

/* rtl/sbms_controller.sv */
// ----------------------------------------------------------------------------
// sbms_controller
// Sequencer over search phases, candidates and block pixels.
// ----------------------------------------------------------------------------
module sbms_controller import sbms_pkg::*; #(
    parameter int MAX_BLOCK_SIDE = MAX_BLOCK_SIDE_DEF,
    localparam int RA = $clog2(MAX_BLOCK_SIDE)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              refine,
    input  logic [RA:0]       w,
    input  logic [RA:0]       h,
    input  logic [3:0]        scope,
    input  logic              better,
    input  logic              div_done,
    input  logic              out_taken,
    output sbms_cmd_t         cmd,
    output logic [RA-1:0]     px,
    output logic [RA-1:0]     py,
    output logic signed [7:0] win_r,
    output logic signed [7:0] win_c,
    output logic              busy,
    output logic              out_valid,
    output logic signed [4:0] mv_x,
    output logic signed [4:0] mv_y,
    output logic              updated
);
    sbms_state_t state_reg, state_next;
    logic [RA-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [4:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [4:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [4:0] bx_reg, bx_next, by_reg, by_next;
    logic coarse_reg, coarse_next, upd_reg, upd_next;
    logic [1:0] drain_reg, drain_next;
    logic signed [4:0] range, stepv;

    assign range = coarse_reg ? 5'(scope) : 5'sd1;
    assign stepv = coarse_reg ? 5'sd2 : 5'sd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        px_reg <= px_next; py_reg <= py_next;
        dx_reg <= dx_next; dy_reg <= dy_next;
        cx_reg <= cx_next; cy_reg <= cy_next;
        bx_reg <= bx_next; by_reg <= by_next;
        coarse_reg <= coarse_next; upd_reg <= upd_next;
        drain_reg <= drain_next;
    end

    always_comb begin
        state_next = state_reg;
        px_next = px_reg; py_next = py_reg;
        dx_next = dx_reg; dy_next = dy_reg;
        cx_next = cx_reg; cy_next = cy_reg;
        bx_next = bx_reg; by_next = by_reg;
        coarse_next = coarse_reg; upd_next = upd_reg;
        drain_next = drain_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    coarse_next = refine;
                    cx_next = '0; cy_next = '0;
                    dx_next = refine ? -5'(scope) : -5'sd1;
                    dy_next = refine ? -5'(scope) : -5'sd1;
                    bx_next = '0; by_next = '0;
                    cmd.clear_best = 1'b1;
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                cmd.clear_sad = 1'b1;
                px_next = '0; py_next = '0;
                state_next = ST_PIX;
            end
            ST_PIX: begin
                cmd.pix_en = 1'b1;
                if ({1'b0, px_reg} == w - 1'b1) begin
                    px_next = '0;
                    if ({1'b0, py_reg} == h - 1'b1) begin
                        drain_next = 2'd2;
                        state_next = ST_DRAIN;
                    end else begin
                        py_next = py_reg + 1'b1;
                    end
                end else begin
                    px_next = px_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg - 1'b1;
                if (drain_reg == 2'd1) state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp = 1'b1;
                if (better) begin
                    bx_next = dx_reg; by_next = dy_reg;
                end
                state_next = ST_NEXTC;
            end
            ST_NEXTC: begin
                if (dx_reg + stepv <= range) begin
                    dx_next = dx_reg + stepv;
                    state_next = ST_CAND;
                end else if (dy_reg + stepv <= range) begin
                    dx_next = -range;
                    dy_next = dy_reg + stepv;
                    state_next = ST_CAND;
                end else if (coarse_reg) begin
                    state_next = ST_PHASE;
                end else begin
                    upd_next = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_PHASE: begin
                if (bx_reg == 0 && by_reg == 0) begin
                    upd_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    coarse_next = 1'b0;
                    cx_next = bx_reg; cy_next = by_reg;
                    bx_next = '0; by_next = '0;
                    dx_next = -5'sd1; dy_next = -5'sd1;
                    cmd.clear_best = 1'b1;
                    state_next = ST_CAND;
                end
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_taken) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign px = px_reg;
    assign py = py_reg;
    assign win_r = 8'(py_reg) + 8'(cy_reg) + 8'(dy_reg) + 8'(scope) + 8'sd1;
    assign win_c = 8'(px_reg) + 8'(cx_reg) + 8'(dx_reg) + 8'(scope) + 8'sd1;
    assign busy = state_reg != ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign updated = upd_reg;
    assign mv_x = upd_reg ? cx_reg + bx_reg : 5'sd0;
    assign mv_y = upd_reg ? cy_reg + by_reg : 5'sd0;
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the SAD block motion search unit. Fills the
// part of both pixel stores that the searches read, then runs directed and
// random load/start traffic under several block sizes and search scopes,
// predicting every search result.
// ----------------------------------------------------------------------------
module tb_top;
    import sbms_pkg::*;

    localparam int REF_SIDE = 32;
    localparam int WIN_SIDE = 48;
    localparam int REF_FILL = 8;     // reference rows and columns filled up front
    localparam int WIN_FILL = 18;    // window rows and columns filled up front
    localparam int CLAMP_SPAN = 34;  // window reach of a 32-pixel side at scope 0
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] val;
        logic       refine;
    } pix_cmd_t;

    typedef struct {
        logic signed [4:0] mv_x;
        logic signed [4:0] mv_y;
        logic [7:0]        mean_sad;
        logic              updated;
    } motion_res_t;

    // Scoreboard: mirrors both stores and the registers, predicts each search.
    class motion_scoreboard;
        logic [7:0]  ref_pix [REF_SIDE*REF_SIDE];
        logic [7:0]  win_pix [WIN_SIDE*WIN_SIDE];
        logic [5:0]  blk_w, blk_h;
        logic [2:0]  scope;
        motion_res_t pending_q[$];
        int          n_err, n_res, n_stale, n_items;

        function new();
            blk_w = 16; blk_h = 16; scope = 4;
            n_err = 0; n_res = 0; n_stale = 0; n_items = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [5:0] v);
            case (idx)
                REG_WIDTH:  blk_w = v;
                REG_HEIGHT: blk_h = v;
                REG_SCOPE:  scope = v[2:0];
                default: ;
            endcase
        endfunction

        function int eff_side(logic [5:0] v);
            if (v == 0) return 1;
            if (v > REF_SIDE) return REF_SIDE;
            return v;
        endfunction

        function int eff_scope();
            return (scope > MAX_SCOPE_DEF) ? MAX_SCOPE_DEF : scope;
        endfunction

        function int unsigned block_cost(int ox, int oy, int w, int h, int base);
            int unsigned sum;
            int wr, wc, a, b;
            sum = 0;
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    wr = y + oy + base;
                    wc = x + ox + base;
                    a = ref_pix[y*REF_SIDE + x];
                    b = 0;
                    if (wr >= 0 && wr < WIN_SIDE && wc >= 0 && wc < WIN_SIDE)
                        b = win_pix[wr*WIN_SIDE + wc];
                    sum += (a > b) ? (a - b) : (b - a);
                end
            end
            return sum;
        endfunction

        // Raster scan of offsets; strict less-than keeps the earliest tie.
        function void scan(input int cx, input int cy, input int range, input int step,
                           input int w, input int h, input int base,
                           output int bx, output int by, output int unsigned best);
            int unsigned s;
            best = 32'h7fffffff; bx = 0; by = 0;
            for (int dy = -range; dy <= range; dy += step) begin
                for (int dx = -range; dx <= range; dx += step) begin
                    s = block_cost(cx + dx, cy + dy, w, h, base);
                    if (s < best) begin
                        best = s; bx = dx; by = dy;
                    end
                end
            end
        endfunction

        function void note_transfer(pix_cmd_t it);
            int w, h, base, cx, cy, fx, fy;
            int unsigned best;
            motion_res_t r;
            n_items++;
            case (it.cmd)
                CMD_LOAD_REF:
                    if (it.row < REF_SIDE && it.col < REF_SIDE)
                        ref_pix[it.row*REF_SIDE + it.col] = it.val;
                CMD_LOAD_WIN:
                    if (it.row < WIN_SIDE && it.col < WIN_SIDE)
                        win_pix[it.row*WIN_SIDE + it.col] = it.val;
                CMD_START: begin
                    w = eff_side(blk_w);
                    h = eff_side(blk_h);
                    base = eff_scope() + 1;
                    cx = 0; cy = 0;
                    r = '{default: 0};
                    if (it.refine)
                        scan(0, 0, eff_scope(), 2, w, h, base, cx, cy, best);
                    if (it.refine && cx == 0 && cy == 0) begin
                        pending_q.push_back(r);
                        return;
                    end
                    scan(cx, cy, 1, 1, w, h, base, fx, fy, best);
                    r.mv_x = 5'(cx + fx);
                    r.mv_y = 5'(cy + fy);
                    r.mean_sad = 8'(best / (w*h));
                    r.updated = 1'b1;
                    pending_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH result %0d %s: got %0d want %0d", n_res, what, got, want);
            n_err++;
        endtask

        task check_result(motion_res_t got);
            motion_res_t want;
            n_res++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = pending_q.pop_front();
            if (!want.updated) n_stale++;
            if (got.mv_x !== want.mv_x) report_mismatch("mv_x", got.mv_x, want.mv_x);
            if (got.mv_y !== want.mv_y) report_mismatch("mv_y", got.mv_y, want.mv_y);
            if (got.mean_sad !== want.mean_sad)
                report_mismatch("mean_sad", got.mean_sad, want.mean_sad);
            if (got.updated !== want.updated)
                report_mismatch("updated", got.updated, want.updated);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    motion_scoreboard sb = new();
    bit send_calm;   // sender: no gaps while set
    bit recv_calm;   // receiver: no stalls while set

    always #5 aclk = ~aclk;

    sad_block_motion_search_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Offer one item; keep tvalid high across back-to-back transfers.
    task send_item(pix_cmd_t it);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge aclk) s_tvalid <= 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.refine, it.val, it.col, it.row, it.cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_transfer(it);
    endtask

    task send_op(logic [1:0] cmd, int row, int col, int val, bit refine);
        pix_cmd_t it;
        it.cmd = cmd; it.row = 6'(row); it.col = 6'(col); it.val = 8'(val);
        it.refine = refine;
        send_item(it);
    endtask

    // Drop tvalid and hold off until every pending search has reported.
    task drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        // loads leave no trace in the queue; give the block time to settle
        repeat (20) @(posedge aclk);
    endtask

    task write_regs(int w, int h, int s, bit touch_unused);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_wdata <= 6'(w);
        @(posedge aclk) sb.set_reg(REG_WIDTH, 6'(w));
        @(negedge aclk);
        cfg_index <= REG_HEIGHT; cfg_wdata <= 6'(h);
        @(posedge aclk) sb.set_reg(REG_HEIGHT, 6'(h));
        @(negedge aclk);
        cfg_index <= REG_SCOPE; cfg_wdata <= 6'(s);
        @(posedge aclk) sb.set_reg(REG_SCOPE, 6'(s));
        if (touch_unused) begin
            @(negedge aclk);
            cfg_index <= REG_NONE; cfg_wdata <= '1;
            @(posedge aclk) sb.set_reg(REG_NONE, '1);
        end
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Paint the reference block into the window at a chosen displacement,
    // then start a search: gives real motion for the search to find.
    task moved_block_search();
        int w, h, base, mx, my, v;
        w = sb.eff_side(sb.blk_w);
        h = sb.eff_side(sb.blk_h);
        base = sb.eff_scope() + 1;
        mx = $urandom_range(0, 2*base) - base;
        my = $urandom_range(0, 2*base) - base;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                v = sb.ref_pix[r*REF_SIDE + c];
                if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 255);
                send_op(CMD_LOAD_WIN, r + my + base, c + mx + base, v, 1'b0);
            end
        end
        send_op(CMD_START, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    task random_items(int n);
        int k, sel;
        k = 0;
        while (k < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // a moved block costs one load per block pixel
                k += sb.eff_side(sb.blk_w) * sb.eff_side(sb.blk_h);
                moved_block_search();
            end else if (sel < 18) begin
                send_op(CMD_START, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255), $urandom_range(0, 1));
            end else if (sel < 40) begin
                send_op(CMD_LOAD_REF, $urandom_range(0, 35), $urandom_range(0, 35),
                        $urandom_range(0, 255), $urandom_range(0, 1));
            end else if (sel < 95) begin
                send_op(CMD_LOAD_WIN, $urandom_range(0, 51), $urandom_range(0, 51),
                        $urandom_range(0, 255), $urandom_range(0, 1));
            end else begin
                // noise: unused command and out-of-range positions
                send_op(($urandom_range(0, 1) ? CMD_NONE : CMD_LOAD_REF),
                        $urandom_range(32, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255), $urandom_range(0, 1));
            end
            k++;
        end
    endtask

    // Receiver: random stall before each transfer, two long hold-offs.
    initial begin
        int stall;
        motion_res_t got;
        forever begin
            stall = recv_calm ? 0 : $urandom_range(0, 4);
            if (sb.n_res == 6 || sb.n_res == 20) stall = 300;
            repeat (stall) @(negedge aclk) m_tready <= 1'b0;
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid));
            got.mv_x     = m_tdata[4:0];
            got.mv_y     = m_tdata[9:5];
            got.mean_sad = m_tdata[17:10];
            got.updated  = m_tdata[18];
            sb.check_result(got);
        end
    end

    // Main sequence. Every shape keeps side + 2*scope + 2 within the filled
    // window, so no search reads a store entry that was never written.
    initial begin
        int ps, side;
        send_calm = 1'b1;
        recv_calm = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // 8x8 block, scope 4; the window holds the reference at zero motion,
        // so the first searches see a perfect match.
        write_regs(8, 8, 4, 1'b0);
        for (int r = 0; r < REF_FILL; r++)
            for (int c = 0; c < REF_FILL; c++)
                send_op(CMD_LOAD_REF, r, c, $urandom_range(0, 255), 1'b0);
        for (int r = 0; r < WIN_FILL; r++)
            for (int c = 0; c < WIN_FILL; c++)
                send_op(CMD_LOAD_WIN, r, c,
                        (r >= 5 && c >= 5 && r < 5 + REF_FILL && c < 5 + REF_FILL) ?
                        sb.ref_pix[(r-5)*REF_SIDE + c-5] : $urandom_range(0, 255), 1'b0);

        // Directed: zero motion both modes, extremes, ignored loads, unused command.
        send_calm = 1'b0;
        send_op(CMD_START, 0, 0, 0, 1'b0);
        send_op(CMD_START, 0, 0, 0, 1'b1);     // coarse lands on zero: not updated
        send_op(CMD_LOAD_REF, 0, 0, 255, 1'b0);
        send_op(CMD_LOAD_REF, 31, 31, 0, 1'b1);
        send_op(CMD_LOAD_REF, 32, 0, 17, 1'b0);
        send_op(CMD_LOAD_REF, 5, 63, 99, 1'b0);
        send_op(CMD_LOAD_WIN, 47, 47, 255, 1'b0);
        send_op(CMD_LOAD_WIN, 48, 3, 1, 1'b0);
        send_op(CMD_LOAD_WIN, 63, 63, 255, 1'b1);
        send_op(CMD_NONE, 63, 63, 255, 1'b1);
        send_op(CMD_START, 63, 63, 255, 1'b0);
        send_op(CMD_START, 0, 0, 0, 1'b1);
        moved_block_search();
        drain();                               // sender waits out all results
        random_items(40);

        // Fill more along the top and left edges for the clamped shapes.
        for (int i = REF_FILL; i < REF_SIDE; i++) begin
            send_op(CMD_LOAD_REF, i, 0, $urandom_range(0, 255), 1'b0);
            send_op(CMD_LOAD_REF, 0, i, $urandom_range(0, 255), 1'b0);
        end
        for (int i = WIN_FILL; i < CLAMP_SPAN; i++) begin
            for (int j = 0; j < 3; j++) begin
                send_op(CMD_LOAD_WIN, i, j, $urandom_range(0, 255), 1'b0);
                send_op(CMD_LOAD_WIN, j, i, $urandom_range(0, 255), 1'b0);
            end
        end

        // 1 x 32 (width 0, height above max), scope 0
        write_regs(0, 40, 0, 1'b1);
        random_items(20);
        // 32 x 1 (width above max, height 0), scope 0
        write_regs(40, 0, 0, 1'b0);
        random_items(20);
        // smallest block, largest scope
        write_regs(1, 1, 7, 1'b1);
        random_items(20);

        for (int p = 0; p < 4; p++) begin
            ps = $urandom_range(0, 7);
            side = (ps == 7) ? 2 : (ps == 6) ? 4 : 6;
            write_regs($urandom_range(1, side), $urandom_range(1, side), ps, p == 2);
            send_calm = (p % 2 == 1);
            recv_calm = (p == 3);
            random_items(25);
        end

        drain();
        repeat (100) @(posedge aclk);
        $display("Covered %0d transfers in, %0d searches checked (%0d not updated).",
                 sb.n_items, sb.n_res, sb.n_stale);
        $display("Blocks 1x1 to 8x8 plus clamped 1x32 and 32x1, scopes 0 to 7, both modes.");
        if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
            $display("sad_block_motion_search_unit regression: pass");
        end else begin
            $display("sad_block_motion_search_unit regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("sad_block_motion_search_unit regression: fail");
        $finish;
    end
endmodule
